FILE: rtl/mrrs_pkg.sv
// Package for the multilevel round-robin scheduler.
// Holds field widths and the command, status and slot state codes.
// No dependencies.
package mrrs_pkg;

   localparam int CMD_W    = 2;
   localparam int TID_W    = 6;
   localparam int LVL_IN_W = 4;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;
   localparam int SSTATE_W = 2;

   localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SLEEP  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SWITCH = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_READY   = 2'd3;

   localparam logic [SSTATE_W-1:0] SLOT_FREE      = 2'd0;
   localparam logic [SSTATE_W-1:0] SLOT_ALLOCATED = 2'd1;
   localparam logic [SSTATE_W-1:0] SLOT_QUEUED    = 2'd2;

endpackage

FILE: rtl/mrrs_ram.sv
// Simple dual-port synchronous RAM with one write and one registered read port.
// Used for the slot table and the level queues; no package dependency.
module mrrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/mrrs_pick.sv
// Priority encoder that finds the highest non-empty level (level 0 first).
// Returns LEVELS when every level is empty; no package dependency.
module mrrs_pick #(
   parameter int LEVELS = 8
) (
   input  logic [LEVELS-1:0]              nonempty,
   output logic [$clog2(LEVELS+1)-1:0]    level
);

   always_comb begin
      level = ($clog2(LEVELS+1))'(LEVELS);
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (nonempty[i]) begin
            level = ($clog2(LEVELS+1))'(i);
         end
      end
   end

endmodule

FILE: rtl/multilevel_round_robin_scheduler.sv
// Multilevel round-robin task scheduler; uses mrrs_pkg, mrrs_ram and mrrs_pick.
// One command at a time; when a task leaves a queue, that queue is scanned entry by
// entry, and an allocate scans the slot table slot by slot from slot 0.
// The slot table and queue RAMs have one read port each.
// Reset is synchronous; after it a clearing pass zeroes the slot table one slot
// at a time, and no command is taken until it ends.
module multilevel_round_robin_scheduler
   import mrrs_pkg::*;
#(
   parameter int TASK_SLOTS  = 64,
   parameter int LEVELS      = 8,
   parameter int QUEUE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // task_id[5:0], level[9:6], priority_req[17:10], zeros
   input  logic [1:0]  req_tuser,  // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // alloc_id[5:0], current_task[11:6], jump[12],
                                   // slice_length[20:13], slice_valid[21], zeros
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   localparam int IW  = $clog2(TASK_SLOTS);
   localparam int LW  = LEVELS > 1 ? $clog2(LEVELS) : 1;
   localparam int AW  = $clog2(LEVELS + 1);
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int QD  = LEVELS * QUEUE_DEPTH;
   localparam int QAW = QD > 1 ? $clog2(QD) : 1;
   localparam int SW  = SSTATE_W + LW + PRIO_W;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_SLOT_RD  = 4'd2;
   localparam logic [3:0] S_SLOT_DEC = 4'd3;
   localparam logic [3:0] S_RT       = 4'd4;
   localparam logic [3:0] S_RT_W     = 4'd5;
   localparam logic [3:0] S_DQ_RD    = 4'd6;
   localparam logic [3:0] S_DQ_W     = 4'd7;
   localparam logic [3:0] S_ENQ      = 4'd8;
   localparam logic [3:0] S_PRIO_RD  = 4'd9;
   localparam logic [3:0] S_PRIO_W   = 4'd10;
   localparam logic [3:0] S_OUT      = 4'd11;

   localparam logic [2:0] RET_DONE    = 3'd0;
   localparam logic [2:0] RET_SLP_OLD = 3'd1;
   localparam logic [2:0] RET_SLP_NEW = 3'd2;
   localparam logic [2:0] RET_SW_OLD  = 3'd3;
   localparam logic [2:0] RET_SW_NEW  = 3'd4;

   logic [3:0]          state_ff, state_in;
   logic [2:0]          ret_ff, ret_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [IW-1:0]       t_ff, t_in;
   logic                inrange_ff, inrange_in;
   logic [LVL_IN_W-1:0] lvl_ff, lvl_in;
   logic [PRIO_W-1:0]   prio_ff, prio_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [LW-1:0]       target_ff, target_in;
   logic                enq_after_ff, enq_after_in;
   logic                was_cur_ff, was_cur_in;
   logic [LW-1:0]       dq_lv_ff, dq_lv_in;
   logic [CW-1:0]       k_ff, k_in;
   logic                found_ff, found_in;
   logic [CW-1:0]       fidx_ff, fidx_in;
   logic                rt_ok_ff, rt_ok_in;
   logic                old_ok_ff, old_ok_in;
   logic [IW-1:0]       old_ff, old_in;
   logic                cur_ok_ff, cur_ok_in;
   logic [IW-1:0]       cur_ff, cur_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [TID_W-1:0]    alloc_ff, alloc_in;
   logic                jump_ff, jump_in;
   logic [PRIO_W-1:0]   slice_ff, slice_in;
   logic                svalid_ff, svalid_in;
   logic [CW-1:0]       cnt_ff [LEVELS];
   logic [CW-1:0]       cnt_in [LEVELS];
   logic [CW-1:0]       ptr_ff [LEVELS];
   logic [CW-1:0]       ptr_in [LEVELS];
   logic [AW-1:0]       act_ff, act_in;
   logic                dirty_ff, dirty_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [23:0]         rsp_data_ff, rsp_data_in;
   logic [1:0]          rsp_user_ff, rsp_user_in;

   logic              slot_we;
   logic [IW-1:0]     slot_waddr, slot_raddr;
   logic [SW-1:0]     slot_wdata, slot_rdata;
   logic              q_we;
   logic [QAW-1:0]    q_waddr, q_raddr;
   logic [IW-1:0]     q_wdata, q_rdata;
   logic [LEVELS-1:0] nonempty;
   logic [AW-1:0]     pick_level;

   logic [SSTATE_W-1:0] s_state;
   logic [LW-1:0]       s_level;
   logic [PRIO_W-1:0]   s_prio;
   logic [LW-1:0]       act_idx;
   logic                rt_cond;
   logic [31:0]         tgt_w, tmp_w, ptr_w;
   logic [LW-1:0]       tgt;
   logic                queued, need_add;

   mrrs_ram #(.WIDTH(SW), .DEPTH(TASK_SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   mrrs_ram #(.WIDTH(IW), .DEPTH(QD)) u_queue_ram (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   // The pick sees the counts as they stand after a removal in the same cycle.
   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         nonempty[i] = cnt_in[i] != '0;
      end
   end

   mrrs_pick #(.LEVELS(LEVELS)) u_pick (
      .nonempty (nonempty),
      .level    (pick_level)
   );

   assign s_prio  = slot_rdata[PRIO_W-1:0];
   assign s_level = slot_rdata[PRIO_W+LW-1:PRIO_W];
   assign s_state = slot_rdata[SW-1:SW-SSTATE_W];
   assign act_idx = act_ff[LW-1:0];
   assign rt_cond = (32'(act_ff) < LEVELS) && (cnt_ff[act_idx] != '0)
                    && (ptr_ff[act_idx] < cnt_ff[act_idx]);

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cmd_in       = cmd_ff;
      t_in         = t_ff;
      inrange_in   = inrange_ff;
      lvl_in       = lvl_ff;
      prio_in      = prio_ff;
      idx_in       = idx_ff;
      target_in    = target_ff;
      enq_after_in = enq_after_ff;
      was_cur_in   = was_cur_ff;
      dq_lv_in     = dq_lv_ff;
      k_in         = k_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;
      rt_ok_in     = rt_ok_ff;
      old_ok_in    = old_ok_ff;
      old_in       = old_ff;
      cur_ok_in    = cur_ok_ff;
      cur_in       = cur_ff;
      status_in    = status_ff;
      alloc_in     = alloc_ff;
      jump_in      = jump_ff;
      slice_in     = slice_ff;
      svalid_in    = svalid_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      act_in       = act_ff;
      dirty_in     = dirty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      slot_we      = 1'b0;
      slot_waddr   = t_ff;
      slot_wdata   = slot_rdata;
      slot_raddr   = (cmd_ff == CMD_ALLOC) ? idx_ff : t_ff;
      q_we         = 1'b0;
      q_waddr      = '0;
      q_wdata      = t_ff;
      q_raddr      = QAW'(32'(act_idx) * QUEUE_DEPTH + 32'(ptr_ff[act_idx]));
      tgt_w        = 32'(lvl_ff[2:0]);
      tgt          = '0;
      queued       = s_state == SLOT_QUEUED;
      need_add     = 1'b0;
      tmp_w        = '0;
      ptr_w        = '0;

      case (state_ff)
         S_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = idx_ff;
            slot_wdata = '0;
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == IW'(TASK_SLOTS - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = req_tuser;
               t_in       = IW'(req_tdata[5:0]);
               inrange_in = 32'(req_tdata[5:0]) < TASK_SLOTS;
               lvl_in     = req_tdata[9:6];
               prio_in    = req_tdata[17:10];
               idx_in     = '0;
               status_in  = ST_OK;
               alloc_in   = '0;
               jump_in    = 1'b0;
               slice_in   = '0;
               svalid_in  = 1'b0;
               ret_in     = RET_DONE;
               if (req_tuser == CMD_SWITCH) begin
                  ret_in   = RET_SW_OLD;
                  state_in = S_RT;
               end else if (req_tuser == CMD_ALLOC || 32'(req_tdata[5:0]) < TASK_SLOTS) begin
                  state_in = S_SLOT_RD;
               end else begin
                  state_in = S_RT;
               end
            end
         end
         S_SLOT_RD: begin
            state_in = S_SLOT_DEC;
         end
         S_SLOT_DEC: begin
            state_in = S_RT;
            ret_in   = RET_DONE;
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (s_state == SLOT_FREE) begin
                     slot_we    = 1'b1;
                     slot_waddr = idx_ff;
                     slot_wdata = {SLOT_ALLOCATED, s_level, s_prio};
                     alloc_in   = TID_W'(idx_ff);
                  end else if (idx_ff == IW'(TASK_SLOTS - 1)) begin
                     status_in = ST_NO_SLOT;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_SLOT_RD;
                  end
               end
               CMD_RUN: begin
                  if (lvl_ff[LVL_IN_W-1]) begin
                     tgt_w = 32'(s_level);
                  end
                  if (tgt_w >= LEVELS) begin
                     tgt_w = LEVELS - 1;
                  end
                  tgt      = LW'(tgt_w);
                  need_add = !(queued && s_level == tgt);
                  if (need_add && 32'(cnt_ff[tgt]) >= QUEUE_DEPTH) begin
                     status_in = ST_QUEUE_FULL;
                  end else begin
                     slot_we    = 1'b1;
                     slot_wdata = {SLOT_QUEUED, tgt, (prio_ff != '0) ? prio_ff : s_prio};
                     dirty_in   = 1'b1;
                     target_in  = tgt;
                     if (queued && need_add) begin
                        enq_after_in = 1'b1;
                        dq_lv_in     = s_level;
                        k_in         = '0;
                        found_in     = 1'b0;
                        state_in     = S_DQ_RD;
                     end else if (need_add) begin
                        state_in = S_ENQ;
                     end
                  end
               end
               CMD_SLEEP: begin
                  if (queued) begin
                     slot_we      = 1'b1;
                     slot_wdata   = {SLOT_ALLOCATED, s_level, s_prio};
                     dq_lv_in     = s_level;
                     enq_after_in = 1'b0;
                     ret_in       = RET_SLP_OLD;
                  end
               end
               default: begin
                  state_in = S_RT;
               end
            endcase
         end
         S_RT: begin
            rt_ok_in = rt_cond;
            state_in = S_RT_W;
         end
         S_RT_W: begin
            case (ret_ff)
               RET_SLP_OLD: begin
                  was_cur_in = rt_ok_ff && q_rdata == t_ff;
                  k_in       = '0;
                  found_in   = 1'b0;
                  state_in   = S_DQ_RD;
               end
               RET_SW_OLD: begin
                  old_ok_in = rt_ok_ff;
                  old_in    = q_rdata;
                  if (rt_ok_ff) begin
                     if (ptr_ff[act_idx] + 1'b1 >= cnt_ff[act_idx]) begin
                        ptr_in[act_idx] = '0;
                     end else begin
                        ptr_in[act_idx] = ptr_ff[act_idx] + 1'b1;
                     end
                  end
                  if (dirty_ff) begin
                     act_in   = pick_level;
                     dirty_in = 1'b0;
                  end
                  ret_in   = RET_SW_NEW;
                  state_in = S_RT;
               end
               RET_SW_NEW: begin
                  cur_ok_in = rt_ok_ff;
                  cur_in    = q_rdata;
                  if (rt_ok_ff) begin
                     state_in = S_PRIO_RD;
                  end else begin
                     status_in = ST_NO_READY;
                     state_in  = S_OUT;
                  end
               end
               RET_SLP_NEW: begin
                  cur_ok_in = rt_ok_ff;
                  cur_in    = q_rdata;
                  if (rt_ok_ff) begin
                     jump_in = 1'b1;
                  end else begin
                     status_in = ST_NO_READY;
                  end
                  state_in = S_OUT;
               end
               default: begin
                  cur_ok_in = rt_ok_ff;
                  cur_in    = q_rdata;
                  state_in  = S_OUT;
               end
            endcase
         end
         S_DQ_RD: begin
            q_raddr = QAW'(32'(dq_lv_ff) * QUEUE_DEPTH + 32'(k_ff));
            if (k_ff == cnt_ff[dq_lv_ff]) begin
               if (found_ff) begin
                  tmp_w = 32'(cnt_ff[dq_lv_ff]) - 1;
                  ptr_w = 32'(ptr_ff[dq_lv_ff]);
                  if (fidx_ff < ptr_ff[dq_lv_ff]) begin
                     ptr_w = ptr_w - 1;
                  end
                  if (ptr_w >= tmp_w) begin
                     ptr_w = '0;
                  end
                  cnt_in[dq_lv_ff] = CW'(tmp_w);
                  ptr_in[dq_lv_ff] = CW'(ptr_w);
               end
               state_in = S_RT;
               ret_in   = RET_DONE;
               if (enq_after_ff) begin
                  state_in = S_ENQ;
               end else if (was_cur_ff) begin
                  act_in   = pick_level;
                  dirty_in = 1'b0;
                  ret_in   = RET_SLP_NEW;
               end
            end else begin
               state_in = S_DQ_W;
            end
         end
         S_DQ_W: begin
            if (found_ff) begin
               q_we    = 1'b1;
               q_waddr = QAW'(32'(dq_lv_ff) * QUEUE_DEPTH + 32'(k_ff) - 1);
               q_wdata = q_rdata;
            end else if (q_rdata == t_ff) begin
               found_in = 1'b1;
               fidx_in  = k_ff;
            end
            k_in     = k_ff + 1'b1;
            state_in = S_DQ_RD;
         end
         S_ENQ: begin
            q_we              = 1'b1;
            q_waddr           = QAW'(32'(target_ff) * QUEUE_DEPTH + 32'(cnt_ff[target_ff]));
            cnt_in[target_ff] = cnt_ff[target_ff] + 1'b1;
            ret_in            = RET_DONE;
            state_in          = S_RT;
         end
         S_PRIO_RD: begin
            slot_raddr = cur_ff;
            state_in   = S_PRIO_W;
         end
         S_PRIO_W: begin
            slice_in  = s_prio;
            svalid_in = 1'b1;
            jump_in   = !old_ok_ff || cur_ff != old_ff;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {2'b00, svalid_ff, slice_ff, jump_ff,
                               cur_ok_ff ? TID_W'(cur_ff) : TID_W'(0), alloc_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         act_ff       <= '0;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            cnt_ff[i] <= '0;
            ptr_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         act_ff       <= act_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff       <= ret_in;
      cmd_ff       <= cmd_in;
      t_ff         <= t_in;
      inrange_ff   <= inrange_in;
      lvl_ff       <= lvl_in;
      prio_ff      <= prio_in;
      target_ff    <= target_in;
      enq_after_ff <= enq_after_in;
      was_cur_ff   <= was_cur_in;
      dq_lv_ff     <= dq_lv_in;
      k_ff         <= k_in;
      found_ff     <= found_in;
      fidx_ff      <= fidx_in;
      rt_ok_ff     <= rt_ok_in;
      old_ok_ff    <= old_ok_in;
      old_ff       <= old_in;
      cur_ok_ff    <= cur_ok_in;
      cur_ff       <= cur_in;
      status_ff    <= status_in;
      alloc_ff     <= alloc_in;
      jump_ff      <= jump_in;
      slice_ff     <= slice_in;
      svalid_ff    <= svalid_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   // A timer reload or a context switch is only reported with an ok status.
   a_slice_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !((rsp_tdata[21] || rsp_tdata[12]) && rsp_tuser != ST_OK))
      else $error("slice_valid or jump with a failing status");

   // The active level never points past the level that means none.
   a_active_range: assert property (@(posedge clock) disable iff (reset)
      32'(act_ff) <= LEVELS)
      else $error("active level out of range");

   // One command is in flight at a time.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command taken while busy");

   // A scan of a level queue never runs past its fill count.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DQ_W |-> k_ff < cnt_ff[dq_lv_ff])
      else $error("queue scan beyond fill count");

   // An out-of-range slot never reaches the slot table for run or sleep.
   a_range_guard: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SLOT_DEC && cmd_ff != CMD_ALLOC |-> inrange_ff)
      else $error("slot table accessed with out-of-range task");

endmodule

FILE: tb/mrrs_checker.sv
// Scoreboard for the multilevel round-robin scheduler: predicts each response
// from its own copy of the slot table and level queues and compares fields.
// Depends on mrrs_pkg.
module mrrs_checker
   import mrrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_count
);

   localparam int NSLOT = 64;
   localparam int NLVL  = 8;
   localparam int QD    = 32;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] alloc_id;
      logic [5:0] current_task;
      logic       jump;
      logic [7:0] slice_length;
      logic       slice_valid;
   } sched_rsp_t;

   logic [1:0] slot_st  [NSLOT];
   logic [2:0] slot_lvl [NSLOT];
   logic [7:0] slot_pri [NSLOT];
   logic [5:0] lq       [NLVL][QD];
   int         lcnt     [NLVL];
   int         lptr     [NLVL];
   int         act_lvl;
   bit         dirty;
   sched_rsp_t expected_rsps[$];

   assign pending_count = expected_rsps.size();

   function automatic bit running(output int t);
      t = 0;
      if (act_lvl >= NLVL || lcnt[act_lvl] == 0 || lptr[act_lvl] >= lcnt[act_lvl])
         return 0;
      t = lq[act_lvl][lptr[act_lvl]];
      return 1;
   endfunction

   function automatic void remove_task(int t);
      int lv, n, i;
      lv = slot_lvl[t];
      slot_st[t] = SLOT_ALLOCATED;
      n = lcnt[lv];
      for (i = 0; i < n; i++)
         if (lq[lv][i] == t) break;
      if (i == n) return;
      n--;
      lcnt[lv] = n;
      if (i < lptr[lv]) lptr[lv]--;
      if (lptr[lv] >= n) lptr[lv] = 0;
      for (; i < n; i++) lq[lv][i] = lq[lv][i+1];
   endfunction

   function automatic void pick_top();
      int i;
      for (i = 0; i < NLVL; i++)
         if (lcnt[i] > 0) break;
      act_lvl = i;
      dirty = 0;
   endfunction

   function automatic sched_rsp_t schedule(logic [1:0] cmd, logic [23:0] d);
      sched_rsp_t r;
      int t, tgt, prio, i, cur, old;
      bit was_cur, had_old, queued, need_add;
      r = '0;
      t = d[5:0];
      prio = d[17:10];
      case (cmd)
         CMD_ALLOC: begin
            for (i = 0; i < NSLOT; i++)
               if (slot_st[i] == SLOT_FREE) break;
            if (i < NSLOT) begin
               slot_st[i] = SLOT_ALLOCATED;
               r.alloc_id = 6'(i);
            end else begin
               r.status = ST_NO_SLOT;
            end
         end
         CMD_RUN: begin
            tgt = d[9] ? int'(slot_lvl[t]) : int'(d[8:6]);
            queued = slot_st[t] == SLOT_QUEUED;
            need_add = !(queued && slot_lvl[t] == tgt);
            if (need_add && lcnt[tgt] >= QD) begin
               r.status = ST_QUEUE_FULL;
            end else begin
               if (prio > 0) slot_pri[t] = 8'(prio);
               if (queued && need_add) remove_task(t);
               if (need_add) begin
                  lq[tgt][lcnt[tgt]] = 6'(t);
                  lcnt[tgt]++;
                  slot_st[t] = SLOT_QUEUED;
                  slot_lvl[t] = 3'(tgt);
               end
               dirty = 1;
            end
         end
         CMD_SLEEP: begin
            if (slot_st[t] == SLOT_QUEUED) begin
               was_cur = running(old) && old == t;
               remove_task(t);
               if (was_cur) begin
                  pick_top();
                  if (running(cur)) r.jump = 1;
                  else r.status = ST_NO_READY;
               end
            end
         end
         default: begin
            had_old = running(old);
            if (had_old) begin
               lptr[act_lvl]++;
               if (lptr[act_lvl] >= lcnt[act_lvl]) lptr[act_lvl] = 0;
            end
            if (dirty) pick_top();
            if (running(cur)) begin
               r.slice_length = slot_pri[cur];
               r.slice_valid = 1;
               r.jump = !had_old || cur != old;
            end else begin
               r.status = ST_NO_READY;
            end
         end
      endcase
      void'(running(cur));
      r.current_task = 6'(cur);
      return r;
   endfunction

   always @(posedge clock) begin
      sched_rsp_t got, want;
      if (reset) begin
         for (int i = 0; i < NSLOT; i++) begin
            slot_st[i] = SLOT_FREE;
            slot_lvl[i] = 0;
            slot_pri[i] = 0;
         end
         for (int l = 0; l < NLVL; l++) begin
            lcnt[l] = 0;
            lptr[l] = 0;
         end
         act_lvl = 0;
         dirty = 0;
         fail_count = 0;
         expected_rsps.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_rsps.push_back(schedule(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.alloc_id = rsp_tdata[5:0];
            got.current_task = rsp_tdata[11:6];
            got.jump = rsp_tdata[12];
            got.slice_length = rsp_tdata[20:13];
            got.slice_valid = rsp_tdata[21];
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("Unexpected response transfer: %p", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want || rsp_tdata[23:22] !== 2'b00) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("Response mismatch: expected %p, actual %p", want, got);
               end
            end
         end
      end
   end

endmodule

FILE: tb/tb_multilevel_round_robin_scheduler.sv
// Top-level testbench for the multilevel round-robin scheduler: drives
// directed and random command transfers with random gaps and stalls.
// Depends on mrrs_pkg, the scheduler RTL and mrrs_checker.
module tb_multilevel_round_robin_scheduler
   import mrrs_pkg::*;
();

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = CMD_ALLOC;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   int          fail_count;
   int          pending_count;
   bit          hold_rsp = 0;
   bit          stim_done = 0;

   always #6 clock = ~clock;

   multilevel_round_robin_scheduler dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   mrrs_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   task automatic send_cmd(logic [1:0] cmd, logic [5:0] tid, logic [3:0] lvl,
                           logic [7:0] prio);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
      req_tuser <= cmd;
      req_tdata <= {6'd0, prio, lvl, tid};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_random(int mode);
      int p;
      logic [3:0] lvl;
      p = $urandom_range(0, 99);
      lvl = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15))
                                        : 4'($urandom_range(0, 7));
      if (mode == 1) lvl = 4'($urandom_range(0, 1));
      if (p < 15)
         send_cmd(CMD_ALLOC, 6'($urandom), 4'($urandom), 8'($urandom));
      else if (p < 50)
         send_cmd(CMD_RUN, 6'($urandom), lvl,
                  ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
      else if (p < 68)
         send_cmd(CMD_SLEEP, 6'($urandom), 4'($urandom), 8'($urandom));
      else
         send_cmd(CMD_SWITCH, 6'($urandom), 4'($urandom), 8'($urandom));
   endtask

   // Response side: random stalls, with one long hold-off on request.
   initial begin
      int g;
      @(negedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end else begin
            g = stim_done ? 0 : gap_len();
            if (g > 0) begin
               rsp_tready <= 0;
               repeat (g) @(negedge clock);
            end
         end
         rsp_tready <= 1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed: switch and sleep with nothing ready, then fill and exercise levels.
      send_cmd(CMD_SWITCH, 6'd0, 4'd0, 8'd0);
      send_cmd(CMD_SLEEP, 6'd5, 4'd0, 8'd0);
      send_cmd(CMD_ALLOC, 6'd0, 4'd0, 8'd0);
      send_cmd(CMD_RUN, 6'd0, 4'd0, 8'd255);
      send_cmd(CMD_RUN, 6'd63, 4'd15, 8'd1);
      send_cmd(CMD_RUN, 6'd7, 4'd7, 8'd0);
      send_cmd(CMD_SWITCH, 6'd0, 4'd0, 8'd0);
      send_cmd(CMD_SWITCH, 6'd0, 4'd0, 8'd0);
      send_cmd(CMD_RUN, 6'd0, 4'd8, 8'd9);
      send_cmd(CMD_RUN, 6'd63, 4'd0, 8'd0);
      send_cmd(CMD_SWITCH, 6'd0, 4'd0, 8'd0);
      send_cmd(CMD_SLEEP, 6'd63, 4'd0, 8'd0);
      send_cmd(CMD_SLEEP, 6'd63, 4'd0, 8'd0);
      send_cmd(CMD_SLEEP, 6'd0, 4'd0, 8'd0);
      send_cmd(CMD_SLEEP, 6'd7, 4'd0, 8'd0);
      send_cmd(CMD_SWITCH, 6'd0, 4'd0, 8'd0);
      for (int i = 0; i < 64; i++) send_cmd(CMD_ALLOC, 6'd0, 4'd0, 8'd0);
      for (int i = 0; i < 33; i++) send_cmd(CMD_RUN, 6'(i), 4'd3, 8'(i + 1));
      hold_rsp = 1;
      for (int i = 0; i < 40; i++) send_cmd(CMD_SWITCH, 6'd0, 4'd0, 8'd0);
      for (int i = 0; i < 40; i++) send_cmd(CMD_SLEEP, 6'($urandom), 4'd0, 8'd0);
      // Random: mostly short queues on all levels, two stretches on two levels.
      for (int i = 0; i < 1450; i++) send_random((i / 300) % 2);
      req_tvalid <= 0;
      stim_done = 1;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("tb_multilevel_round_robin_scheduler passed");
      else
         $display("tb_multilevel_round_robin_scheduler failed");
      $finish;
   end

   initial begin
      #(12 * 5000000);
      $display("tb_multilevel_round_robin_scheduler failed");
      $finish;
   end

endmodule
